// File: design/marching_squares_tile_paste_assert.svh
// Assertion macros for the marching squares tile paster.
// Depends on nothing; the including module supplies clk_i and rst_ni.
`ifndef MARCHING_SQUARES_TILE_PASTE_ASSERT_SVH
`define MARCHING_SQUARES_TILE_PASTE_ASSERT_SVH

// Plain property, checked on every clock edge outside reset.
`define MSTP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Overlapping implication, checked on every clock edge outside reset.
`define MSTP_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// File: design/mstp_pkg.sv
// Shared constants, types and register codes of the marching squares tile paster.
// Depends on nothing; used by marching_squares_tile_paste.
package mstp_pkg;

  // Tile geometry and store sizes.
  localparam int TILE_SIDE  = 8;
  localparam int TILE_COUNT = 16;
  localparam int GRID_MAX   = 512;
  localparam int TILE_AREA  = TILE_SIDE * TILE_SIDE;

  localparam int SIDE_W    = $clog2(TILE_SIDE);
  localparam int OFF_W     = $clog2(TILE_AREA);
  localparam int KASE_W    = $clog2(TILE_COUNT);
  localparam int TILE_AW   = KASE_W + OFF_W;
  localparam int TILE_DEPTH = TILE_COUNT * TILE_AREA;
  localparam int CNT_W     = $clog2(GRID_MAX);
  localparam int SIZE_W    = CNT_W + 1;

  // Field widths of the items.
  localparam int COLOR_W  = 8;
  localparam int RGB_W    = 3 * COLOR_W;
  localparam int CELL_W   = 9;
  localparam int PIX_W    = 3;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 48;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS = 2'd2;

  localparam logic [COLOR_W-1:0] THRESHOLD_RESET = 8'd200;
  localparam logic [SIZE_W-1:0]  GRID_SIZE_RESET = 10'd257;
  localparam logic [SIZE_W-1:0]  GRID_SIZE_MIN   = 10'd2;
  localparam logic [SIZE_W-1:0]  GRID_SIZE_MAX   = SIZE_W'(GRID_MAX);

  // Input command codes carried on tuser.
  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  // One result item as it waits in the output buffer.
  typedef struct packed {
    logic [CELL_W-1:0]  cell_row;
    logic [CELL_W-1:0]  cell_col;
    logic [PIX_W-1:0]   pix_row;
    logic [PIX_W-1:0]   pix_col;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
    logic               last;
  } out_item_t;

  // Clamp a configured grid size into the supported range.
  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v);
    logic [SIZE_W-1:0] r;
    if (v < GRID_SIZE_MIN) begin
      r = GRID_SIZE_MIN;
    end else if (v > GRID_SIZE_MAX) begin
      r = GRID_SIZE_MAX;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

// File: design/mstp_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Depends on nothing; instantiated by marching_squares_tile_paste.
module mstp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port with registered data, which holds between reads.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/marching_squares_tile_paste.sv
// Marching squares tile paster: classifies grid samples and streams the matching tile.
// A load item is written in its accept cycle; a sample that completes a cell passes
// through the lookup state, then streams its 64 tile pixels, one pixel per cycle while
// the output is not stalled. No input is taken during lookup or emit; loads are taken
// one per cycle while idle. Reset clears counters, corner bits and
// the output buffer and loads threshold 200 and grid size 257; memories are not cleared.
`include "marching_squares_tile_paste_assert.svh"

module marching_squares_tile_paste (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Configuration write channel.
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [mstp_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [mstp_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  // Input stream.
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // tile_index[3:0], tile_offset[9:4], red[17:10], green[25:18], blue[33:26], zero fill
  input  logic [mstp_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // cmd[0]
  input  logic                               s_axis_tuser,
  // Output stream.
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // cell_row[8:0], cell_col[17:9], pix_row[20:18], pix_col[23:21],
  // out_red[31:24], out_green[39:32], out_blue[47:40]
  output logic [mstp_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  output logic                               m_axis_tlast
);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_LOOKUP = 3'b010,
    ST_EMIT   = 3'b100
  } state_e;

  localparam int ISSUE_W = mstp_pkg::OFF_W + 1;

  state_e st_q, st_d;

  // Configuration registers.
  logic [mstp_pkg::COLOR_W-1:0] threshold_q;
  logic [mstp_pkg::SIZE_W-1:0]  grid_cols_q, grid_rows_q;
  logic [mstp_pkg::SIZE_W-1:0]  cols, rows;

  // Grid walk state.
  logic [mstp_pkg::CNT_W-1:0] row_cnt_q, row_cnt_d, col_cnt_q, col_cnt_d;
  logic                       left_q, above_left_q;
  logic [mstp_pkg::CNT_W-1:0] row_q, col_q;
  logic                       bit_q;
  logic [mstp_pkg::KASE_W-1:0] kase_q;

  // Emit sequencing.
  logic [ISSUE_W-1:0]         issue_cnt_q;
  logic                       pend_q;
  logic [mstp_pkg::OFF_W-1:0] rd_idx_q;
  logic                       rd_issue;

  // Output buffer of two items.
  mstp_pkg::out_item_t ob_q [2];
  mstp_pkg::out_item_t ob_d [2];
  mstp_pkg::out_item_t new_item;
  logic [1:0]          occ_q, occ_d, occ_mid;
  logic [2:0]          room_use;
  logic                pop;

  // Input field decode.
  logic                         in_cmd;
  logic [mstp_pkg::KASE_W-1:0]  in_tile_index;
  logic [mstp_pkg::OFF_W-1:0]   in_tile_offset;
  logic [mstp_pkg::COLOR_W-1:0] in_red, in_green, in_blue;
  logic                         in_acc, acc_load, acc_sample;

  // Sample classification and position.
  logic [mstp_pkg::SIZE_W-1:0]  sum, limit;
  logic                         sample_bit;
  logic                         col_wrap;
  logic [mstp_pkg::CNT_W-1:0]   col_cur, row_cur;
  logic [mstp_pkg::SIZE_W-1:0]  row_inc, col_nxt, row_nxt;

  // Memory ports.
  logic                        line_rdata;
  logic [mstp_pkg::RGB_W-1:0]  tile_rdata;
  logic                        tile_we;

  assign in_cmd         = s_axis_tuser;
  assign in_tile_index  = s_axis_tdata[3:0];
  assign in_tile_offset = s_axis_tdata[9:4];
  assign in_red         = s_axis_tdata[17:10];
  assign in_green       = s_axis_tdata[25:18];
  assign in_blue        = s_axis_tdata[33:26];

  assign s_axis_tready = (st_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign acc_load      = in_acc && (in_cmd == mstp_pkg::CMD_LOAD);
  assign acc_sample    = in_acc && (in_cmd == mstp_pkg::CMD_SAMPLE);

  assign cfg_ready_o = 1'b1;

  assign cols = mstp_pkg::clamp_size(grid_cols_q);
  assign rows = mstp_pkg::clamp_size(grid_rows_q);

  // A point is outside when floor(sum/3) > threshold, that is sum > 3*threshold + 2.
  always_comb begin
    sum   = mstp_pkg::SIZE_W'(in_red) + mstp_pkg::SIZE_W'(in_green)
          + mstp_pkg::SIZE_W'(in_blue);
    limit = mstp_pkg::SIZE_W'({threshold_q, 1'b0}) + mstp_pkg::SIZE_W'(threshold_q)
          + mstp_pkg::SIZE_W'(2);
    sample_bit = !(sum > limit);
  end

  // Position of this sample, wrapping first if the grid size shrank, and the next one.
  always_comb begin
    col_wrap = ({1'b0, col_cnt_q} >= cols);
    col_cur  = col_wrap ? '0 : col_cnt_q;
    row_inc  = {1'b0, row_cnt_q} + (col_wrap ? mstp_pkg::SIZE_W'(1) : '0);
    row_cur  = (row_inc >= rows) ? '0 : row_inc[mstp_pkg::CNT_W-1:0];
    col_nxt  = {1'b0, col_cur} + mstp_pkg::SIZE_W'(1);
    row_nxt  = {1'b0, row_cur} + mstp_pkg::SIZE_W'(1);
    row_cnt_d = row_cnt_q;
    col_cnt_d = col_cnt_q;
    if (acc_sample) begin
      if (col_nxt >= cols) begin
        col_cnt_d = '0;
        row_cnt_d = (row_nxt >= rows) ? '0 : row_nxt[mstp_pkg::CNT_W-1:0];
      end else begin
        col_cnt_d = col_nxt[mstp_pkg::CNT_W-1:0];
        row_cnt_d = row_cur;
      end
    end
  end

  // Line memory: one bit per grid column of the previous row.
  mstp_ram #(
    .WIDTH (1),
    .DEPTH (mstp_pkg::GRID_MAX)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (st_q == ST_LOOKUP),
    .waddr_i (col_q),
    .wdata_i (bit_q),
    .re_i    (acc_sample),
    .raddr_i (col_cur),
    .rdata_o (line_rdata)
  );

  // Tile memory: TILE_COUNT tiles of TILE_AREA pixels.
  assign tile_we = acc_load
                && ({1'b0, in_tile_offset} < ISSUE_W'(mstp_pkg::TILE_AREA));

  mstp_ram #(
    .WIDTH (mstp_pkg::RGB_W),
    .DEPTH (mstp_pkg::TILE_DEPTH)
  ) u_tile_ram (
    .clk_i   (clk_i),
    .we_i    (tile_we),
    .waddr_i ({in_tile_index, in_tile_offset}),
    .wdata_i ({in_red, in_green, in_blue}),
    .re_i    (rd_issue),
    .raddr_i ({kase_q, issue_cnt_q[mstp_pkg::OFF_W-1:0]}),
    .rdata_o (tile_rdata)
  );

  // Read issue: only while the buffer has room for the item and the one in flight.
  assign pop      = m_axis_tvalid && m_axis_tready;
  assign occ_mid  = occ_q - {1'b0, pop};
  assign room_use = {1'b0, occ_mid} + {2'b0, pend_q};
  assign rd_issue = (st_q == ST_EMIT)
                 && (issue_cnt_q < ISSUE_W'(mstp_pkg::TILE_AREA))
                 && (room_use < 3'd2);

  // Item built from the read data returning this cycle.
  always_comb begin
    new_item.cell_row = row_q - mstp_pkg::CNT_W'(1);
    new_item.cell_col = col_q - mstp_pkg::CNT_W'(1);
    new_item.pix_row  = rd_idx_q[mstp_pkg::SIDE_W +: mstp_pkg::SIDE_W];
    new_item.pix_col  = rd_idx_q[0 +: mstp_pkg::SIDE_W];
    new_item.red      = tile_rdata[2*mstp_pkg::COLOR_W +: mstp_pkg::COLOR_W];
    new_item.green    = tile_rdata[mstp_pkg::COLOR_W +: mstp_pkg::COLOR_W];
    new_item.blue     = tile_rdata[0 +: mstp_pkg::COLOR_W];
    new_item.last     = (rd_idx_q == mstp_pkg::OFF_W'(mstp_pkg::TILE_AREA - 1));
  end

  // Output buffer update: shift on pop, append the returning read.
  always_comb begin
    ob_d[0] = pop ? ob_q[1] : ob_q[0];
    ob_d[1] = ob_q[1];
    if (pend_q) begin
      ob_d[occ_mid[0]] = new_item;
    end
    occ_d = occ_mid + {1'b0, pend_q};
  end

  assign m_axis_tvalid = (occ_q != 2'd0);
  assign m_axis_tdata  = {ob_q[0].blue, ob_q[0].green, ob_q[0].red, ob_q[0].pix_col,
                          ob_q[0].pix_row, ob_q[0].cell_col, ob_q[0].cell_row};
  assign m_axis_tlast  = ob_q[0].last;

  // Sequencer.
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      ST_IDLE: begin
        if (acc_sample) begin
          st_d = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        st_d = ((row_q != '0) && (col_q != '0)) ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        if ((issue_cnt_q == ISSUE_W'(mstp_pkg::TILE_AREA)) && !pend_q) begin
          st_d = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q         <= ST_IDLE;
      threshold_q  <= mstp_pkg::THRESHOLD_RESET;
      grid_cols_q  <= mstp_pkg::GRID_SIZE_RESET;
      grid_rows_q  <= mstp_pkg::GRID_SIZE_RESET;
      row_cnt_q    <= '0;
      col_cnt_q    <= '0;
      left_q       <= 1'b0;
      above_left_q <= 1'b0;
      issue_cnt_q  <= '0;
      pend_q       <= 1'b0;
      occ_q        <= '0;
    end else begin
      st_q      <= st_d;
      row_cnt_q <= row_cnt_d;
      col_cnt_q <= col_cnt_d;
      pend_q    <= rd_issue;
      occ_q     <= occ_d;
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          mstp_pkg::CFG_THRESHOLD: threshold_q <= cfg_data_i[mstp_pkg::COLOR_W-1:0];
          mstp_pkg::CFG_GRID_COLS: grid_cols_q <= cfg_data_i;
          mstp_pkg::CFG_GRID_ROWS: grid_rows_q <= cfg_data_i;
          default: ;
        endcase
      end
      // Corner bits shift once the bit above is read back.
      if (st_q == ST_LOOKUP) begin
        left_q       <= bit_q;
        above_left_q <= line_rdata;
        issue_cnt_q  <= '0;
      end else if (rd_issue) begin
        issue_cnt_q <= issue_cnt_q + ISSUE_W'(1);
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (acc_sample) begin
      row_q <= row_cur;
      col_q <= col_cur;
      bit_q <= sample_bit;
    end
    if (st_q == ST_LOOKUP) begin
      kase_q <= {above_left_q, line_rdata, bit_q, left_q};
    end
    if (rd_issue) begin
      rd_idx_q <= issue_cnt_q[mstp_pkg::OFF_W-1:0];
    end
    ob_q[0] <= ob_d[0];
    ob_q[1] <= ob_d[1];
  end

  // Checks on the buffer and read sequencing.
  `MSTP_ASSERT(a_occ_range, occ_q != 2'd3, "output buffer count out of range")
  `MSTP_IMPLY(a_push_room, pend_q, occ_mid < 2'd2, "returning read finds no buffer room")
  `MSTP_IMPLY(a_idle_quiet, st_q == ST_IDLE, !pend_q, "tile read pending while idle")
  `MSTP_IMPLY(a_pend_src, pend_q, $past(rd_issue), "read data without an issued read")

endmodule
